/* hdl/tlm_pkg.sv */
// Shared payload types, request codes and sequencer states of the longest-match tokenizer.
`default_nettype none

package tlm_pkg;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_byte;
        logic [11:0] piece_id;
        logic        last_char;
    } tok_in_t;

    typedef struct packed {
        logic [11:0] token_id;
        logic        is_fallback;
        logic [7:0]  byte_value;
        logic [4:0]  token_length;
        logic        end_of_word;
        logic        last;
        logic        table_overflow;
    } tok_out_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEXT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_CHECK,
        ST_LD_CMP,
        ST_LD_CREATE,
        ST_LD_LINK,
        ST_LD_FIN,
        ST_TX_START,
        ST_TX_ISSUE,
        ST_TX_CMP,
        ST_TX_EMIT,
        ST_TX_PUSH
    } tlm_state_t;

endpackage

`default_nettype wire

/* hdl/tlm_trie.sv */
// Trie node memories: edge byte and sibling link, first child, and piece id per node.
`default_nettype none

module tlm_trie #(
    parameter int NW = 10
) (
    input  wire logic          clk,
    input  wire logic [NW-1:0] rd_addr,
    output logic [7:0]         rd_ch,
    output logic [NW-1:0]      rd_sib,
    output logic [NW-1:0]      rd_child,
    output logic               rd_pv,
    output logic [11:0]        rd_pid,
    input  wire logic          node_we,
    input  wire logic [NW-1:0] node_waddr,
    input  wire logic [7:0]    node_wch,
    input  wire logic [NW-1:0] node_wsib,
    input  wire logic          child_we,
    input  wire logic [NW-1:0] child_waddr,
    input  wire logic [NW-1:0] child_wdata,
    input  wire logic          piece_we,
    input  wire logic [NW-1:0] piece_waddr,
    input  wire logic          piece_wvalid,
    input  wire logic [11:0]   piece_wid
);

    localparam int DEPTH = 1 << NW;

    logic [7+NW:0] node_mem  [DEPTH];
    logic [NW-1:0] child_mem [DEPTH];
    logic [12:0]   piece_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= {node_wch, node_wsib};
        end
        {rd_ch, rd_sib} <= node_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
        rd_child <= child_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (piece_we)
        begin
            piece_mem[piece_waddr] <= {piece_wvalid, piece_wid};
        end
        {rd_pv, rd_pid} <= piece_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hdl/trie_longest_match_tokenizer.sv */
// Top level of the greedy longest-match tokenizer over a byte trie.
// One input channel (in_valid/in_ready/in_data) carries load bytes and text bytes.
// A load byte extends the vocabulary trie; the final byte of a piece records its id.
// A text byte is appended to a lookahead buffer of MAX_PIECE_LEN bytes, and every
// token whose longest match is decided is sent on the output channel
// (out_valid/out_ready/out_data), the last token of the item carrying last.
// Each input transfer is processed alone: in_ready is high only while the sequencer
// is idle. A trie lookup walks the sibling list of a node, one node memory read per
// cycle. A load byte visits the siblings it compares, and when it creates a node it
// writes the node, then links it into its parent. A text byte compares siblings and
// matches bytes; every emitted token adds an emit step, a push step and a fresh walk
// of the bytes left in the buffer. The output register lets the next input transfer
// be taken while a token waits. When the receiver stalls, the sequencer holds the
// next token until the output register is free. Reset empties the trie and the
// buffer at once: node memories need no clearing, since only nodes below the node
// count are ever reached.
`default_nettype none

module trie_longest_match_tokenizer
    import tlm_pkg::*;
#(
    parameter int MAX_NODES     = 1024,
    parameter int MAX_PIECE_LEN = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire tok_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output tok_out_t     out_data
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int IW = (MAX_PIECE_LEN > 2) ? $clog2(MAX_PIECE_LEN) : 1;
    localparam int LW = $clog2(MAX_PIECE_LEN + 1);

    tlm_state_t    state_reg, state_next;
    logic [7:0]    c_reg, c_next;
    logic [11:0]   id_reg, id_next;
    logic          fin_reg, fin_next;
    logic [NW-1:0] insert_reg, insert_next;
    logic [NW-1:0] ins_head_reg, ins_head_next;
    logic [LW-1:0] depth_reg, depth_next;
    logic          dropped_reg, dropped_next;
    logic          ovf_reg, ovf_next;
    logic [NW-1:0] root_child_reg, root_child_next;
    logic [CW-1:0] node_count_reg, node_count_next;
    logic [7:0]    buf_reg [MAX_PIECE_LEN];
    logic [7:0]    buf_next [MAX_PIECE_LEN];
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] j_reg, j_next;
    logic [NW-1:0] ptr_reg, ptr_next;
    logic          found_reg, found_next;
    logic [11:0]   best_id_reg, best_id_next;
    logic [LW-1:0] best_len_reg, best_len_next;
    logic          has_row_reg, has_row_next;
    logic          ret_idle_reg, ret_idle_next;
    tok_out_t      row_reg, row_next;
    logic          out_valid_reg, out_valid_next;
    tok_out_t      out_reg, out_next;

    logic [NW-1:0] rd_addr;
    logic [7:0]    rd_ch;
    logic [NW-1:0] rd_sib;
    logic [NW-1:0] rd_child;
    logic          rd_pv;
    logic [11:0]   rd_pid;
    logic          node_we, child_we, piece_we, piece_wvalid;
    logic [NW-1:0] node_waddr, node_wsib, child_waddr, child_wdata, piece_waddr;
    logic [11:0]   piece_wid;

    logic [NW-1:0] parent_head;
    logic [NW-1:0] new_node;
    logic          room;
    logic          full_buf;
    logic [7:0]    walk_byte;
    logic [LW-1:0] take_len;
    logic [LW-1:0] count_left;
    logic [LW:0]   sidx;

    tlm_trie #(
        .NW(NW)
    ) u_trie (
        .clk         (clk),
        .rd_addr     (rd_addr),
        .rd_ch       (rd_ch),
        .rd_sib      (rd_sib),
        .rd_child    (rd_child),
        .rd_pv       (rd_pv),
        .rd_pid      (rd_pid),
        .node_we     (node_we),
        .node_waddr  (node_waddr),
        .node_wch    (c_reg),
        .node_wsib   (node_wsib),
        .child_we    (child_we),
        .child_waddr (child_waddr),
        .child_wdata (child_wdata),
        .piece_we    (piece_we),
        .piece_waddr (piece_waddr),
        .piece_wvalid(piece_wvalid),
        .piece_wid   (piece_wid)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Head of the child list of the node the current piece has reached.
    assign parent_head = (insert_reg == '0) ? root_child_reg : ins_head_reg;
    assign new_node    = node_count_reg[NW-1:0];
    assign room        = (node_count_reg < CW'(MAX_NODES));
    assign full_buf    = (count_reg >= LW'(MAX_PIECE_LEN));
    assign walk_byte   = buf_reg[j_reg[IW-1:0]];
    assign take_len    = found_reg ? best_len_reg : LW'(1);
    assign count_left  = count_reg - take_len;

    always_comb
    begin
        state_next      = state_reg;
        c_next          = c_reg;
        id_next         = id_reg;
        fin_next        = fin_reg;
        insert_next     = insert_reg;
        ins_head_next   = ins_head_reg;
        depth_next      = depth_reg;
        dropped_next    = dropped_reg;
        ovf_next        = ovf_reg;
        root_child_next = root_child_reg;
        node_count_next = node_count_reg;
        buf_next        = buf_reg;
        count_next      = count_reg;
        j_next          = j_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        best_id_next    = best_id_reg;
        best_len_next   = best_len_reg;
        has_row_next    = has_row_reg;
        ret_idle_next   = ret_idle_reg;
        row_next        = row_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        rd_addr         = ptr_reg;
        node_we         = 1'b0;
        node_waddr      = new_node;
        node_wsib       = parent_head;
        child_we        = 1'b0;
        child_waddr     = new_node;
        child_wdata     = '0;
        piece_we        = 1'b0;
        piece_waddr     = new_node;
        piece_wvalid    = 1'b0;
        piece_wid       = id_reg;
        sidx            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    c_next   = in_data.char_byte;
                    id_next  = in_data.piece_id;
                    fin_next = in_data.last_char;
                    if (in_data.req_type == REQ_LOAD)
                    begin
                        state_next = ST_LD_CHECK;
                    end
                    else
                    begin
                        if (!full_buf)
                        begin
                            buf_next[count_reg[IW-1:0]] = in_data.char_byte;
                            count_next = count_reg + LW'(1);
                        end
                        has_row_next = 1'b0;
                        state_next   = ST_TX_START;
                    end
                end
            end

            ST_LD_CHECK:
            begin
                if (dropped_reg)
                begin
                    state_next = ST_LD_FIN;
                end
                else if (depth_reg >= LW'(MAX_PIECE_LEN))
                begin
                    dropped_next = 1'b1;
                    ovf_next     = 1'b1;
                    state_next   = ST_LD_FIN;
                end
                else if (parent_head == '0)
                begin
                    if (room)
                    begin
                        state_next = ST_LD_CREATE;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                        ovf_next     = 1'b1;
                        state_next   = ST_LD_FIN;
                    end
                end
                else
                begin
                    ptr_next   = parent_head;
                    rd_addr    = parent_head;
                    state_next = ST_LD_CMP;
                end
            end

            ST_LD_CMP:
            begin
                if (rd_ch == c_reg)
                begin
                    insert_next   = ptr_reg;
                    ins_head_next = rd_child;
                    depth_next    = depth_reg + LW'(1);
                    state_next    = ST_LD_FIN;
                end
                else if (rd_sib == '0)
                begin
                    if (room)
                    begin
                        state_next = ST_LD_CREATE;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                        ovf_next     = 1'b1;
                        state_next   = ST_LD_FIN;
                    end
                end
                else
                begin
                    ptr_next = rd_sib;
                    rd_addr  = rd_sib;
                end
            end

            ST_LD_CREATE:
            begin
                // The new node goes to the front of its parent's child list.
                node_we    = 1'b1;
                child_we   = 1'b1;
                piece_we   = 1'b1;
                state_next = ST_LD_LINK;
            end

            ST_LD_LINK:
            begin
                if (insert_reg == '0)
                begin
                    root_child_next = new_node;
                end
                else
                begin
                    child_we    = 1'b1;
                    child_waddr = insert_reg;
                    child_wdata = new_node;
                end
                insert_next     = new_node;
                ins_head_next   = '0;
                depth_next      = depth_reg + LW'(1);
                node_count_next = node_count_reg + CW'(1);
                state_next      = ST_LD_FIN;
            end

            ST_LD_FIN:
            begin
                if (fin_reg)
                begin
                    if (!dropped_reg)
                    begin
                        piece_we     = 1'b1;
                        piece_waddr  = insert_reg;
                        piece_wvalid = 1'b1;
                    end
                    insert_next   = '0;
                    ins_head_next = '0;
                    depth_next    = '0;
                    dropped_next  = 1'b0;
                end
                state_next = ST_IDLE;
            end

            ST_TX_START:
            begin
                j_next        = '0;
                ptr_next      = root_child_reg;
                found_next    = 1'b0;
                best_id_next  = '0;
                best_len_next = '0;
                state_next    = ST_TX_ISSUE;
            end

            ST_TX_ISSUE:
            begin
                if (j_reg == count_reg || ptr_reg == '0)
                begin
                    // Walk ends here: a trie miss, or every buffered byte matched.
                    if (ptr_reg != '0 && j_reg == count_reg && !fin_reg && !full_buf)
                    begin
                        ret_idle_next = 1'b1;
                        state_next    = has_row_reg ? ST_TX_PUSH : ST_IDLE;
                    end
                    else if (j_reg == count_reg && !fin_reg && !full_buf)
                    begin
                        ret_idle_next = 1'b1;
                        state_next    = has_row_reg ? ST_TX_PUSH : ST_IDLE;
                    end
                    else
                    begin
                        ret_idle_next = 1'b0;
                        state_next    = has_row_reg ? ST_TX_PUSH : ST_TX_EMIT;
                    end
                end
                else
                begin
                    rd_addr    = ptr_reg;
                    state_next = ST_TX_CMP;
                end
            end

            ST_TX_CMP:
            begin
                if (rd_ch == walk_byte)
                begin
                    if (rd_pv)
                    begin
                        found_next    = 1'b1;
                        best_id_next  = rd_pid;
                        best_len_next = j_reg + LW'(1);
                    end
                    ptr_next   = rd_child;
                    j_next     = j_reg + LW'(1);
                    state_next = ST_TX_ISSUE;
                end
                else if (rd_sib == '0)
                begin
                    // A miss always decides the match.
                    ret_idle_next = 1'b0;
                    state_next    = has_row_reg ? ST_TX_PUSH : ST_TX_EMIT;
                end
                else
                begin
                    ptr_next = rd_sib;
                    rd_addr  = rd_sib;
                end
            end

            ST_TX_EMIT:
            begin
                row_next.token_id       = found_reg ? best_id_reg : '0;
                row_next.is_fallback    = !found_reg;
                row_next.byte_value     = buf_reg[0];
                row_next.token_length   = 5'(take_len);
                row_next.end_of_word    = fin_reg && (count_left == '0);
                row_next.last           = 1'b0;
                row_next.table_overflow = 1'b0;
                for (int k = 0; k < MAX_PIECE_LEN; k++)
                begin
                    sidx = (LW+1)'(k) + {1'b0, take_len};
                    if (sidx < (LW+1)'(MAX_PIECE_LEN))
                    begin
                        buf_next[k] = buf_reg[sidx[IW-1:0]];
                    end
                end
                count_next = count_left;
                if (count_left == '0)
                begin
                    ret_idle_next = 1'b1;
                    state_next    = ST_TX_PUSH;
                end
                else
                begin
                    has_row_next = 1'b1;
                    state_next   = ST_TX_START;
                end
            end

            ST_TX_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next                = row_reg;
                    out_next.last           = ret_idle_reg;
                    out_next.table_overflow = ovf_reg;
                    out_valid_next          = 1'b1;
                    has_row_next            = 1'b0;
                    state_next              = ret_idle_reg ? ST_IDLE : ST_TX_EMIT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            insert_reg     <= '0;
            ins_head_reg   <= '0;
            depth_reg      <= '0;
            dropped_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            root_child_reg <= '0;
            node_count_reg <= CW'(1);
            count_reg      <= '0;
            has_row_reg    <= 1'b0;
            ret_idle_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            insert_reg     <= insert_next;
            ins_head_reg   <= ins_head_next;
            depth_reg      <= depth_next;
            dropped_reg    <= dropped_next;
            ovf_reg        <= ovf_next;
            root_child_reg <= root_child_next;
            node_count_reg <= node_count_next;
            count_reg      <= count_next;
            has_row_reg    <= has_row_next;
            ret_idle_reg   <= ret_idle_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        id_reg       <= id_next;
        fin_reg      <= fin_next;
        buf_reg      <= buf_next;
        j_reg        <= j_next;
        ptr_reg      <= ptr_next;
        found_reg    <= found_next;
        best_id_reg  <= best_id_next;
        best_len_reg <= best_len_next;
        row_reg      <= row_next;
        out_reg      <= out_next;
    end

    // The buffer never holds more than one maximal piece.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LW'(MAX_PIECE_LEN))
        else $error("lookahead count beyond buffer depth");

    // The node count starts at the root and never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg >= CW'(1) && node_count_reg <= CW'(MAX_NODES))
        else $error("node count out of range");

    // A compare cycle always looks at a real node, never at the root.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TX_CMP || state_reg == ST_LD_CMP) |-> ptr_reg != '0)
        else $error("trie compare on null pointer");

    // A fallback token is one byte with id zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.is_fallback) |->
            (out_reg.token_length == 5'd1 && out_reg.token_id == 12'd0))
        else $error("malformed fallback token");

    // A word-final token always closes its input item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.end_of_word) |-> out_reg.last)
        else $error("end of word without last");

endmodule

`default_nettype wire
